// ===== rtl/fdd_pkg.sv =====
package fdd_pkg;

    // Sizing of the sample set and of the arithmetic.
    localparam int FDD_MAX_POINTS = 7;
    localparam int Y_W    = 32;
    localparam int X_W    = 32;
    localparam int ORDERS = 6;
    localparam int ORD_W  = 3;
    localparam int DIFF_W = 38;
    localparam int COEF_W = 9;
    localparam int ACC_W  = 48;
    localparam int HMAG_W = 32;
    localparam int DEN_W  = 72;
    localparam int NUM_W  = 79;
    localparam int QCNT_W = $clog2(NUM_W + 1);
    localparam int OUT_W  = 48;
    localparam int STEP_W = 4;

    localparam logic signed [OUT_W-1:0] POS_LIM = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] NEG_LIM = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_ZERO = 2'd2,
        ST_SAT  = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [X_W-1:0] x_position;
        logic signed [Y_W-1:0] y_value;
        logic                  last_sample;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] first_derivative;
        logic signed [OUT_W-1:0] second_derivative;
        logic [1:0]              status;
    } result_t;

    // Datapath operations, one per control word.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_NOP,
        OP_INIT,
        OP_DIFF,
        OP_ACC,
        OP_DEN1,
        OP_NUM1,
        OP_DIV,
        OP_FIN1,
        OP_SQR,
        OP_DEN2,
        OP_NUM2,
        OP_FIN2,
        OP_EMIT
    } op_t;

    // Jump conditions; a jump not taken falls through to the next step.
    typedef enum logic [2:0] {
        C_NEXT,
        C_GOTO,
        C_WAIT,
        C_BAD,
        C_ORDER,
        C_DIV,
        C_BUSY
    } cond_t;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    // Status returned by the datapath to the sequencer.
    typedef struct packed {
        logic pending;
        logic bad;
        logic order_more;
        logic div_more;
        logic out_busy;
    } flags_t;

    localparam step_t S_IDLE  = 4'd0;
    localparam step_t S_INIT  = 4'd1;
    localparam step_t S_CHECK = 4'd2;
    localparam step_t S_DIFF  = 4'd3;
    localparam step_t S_ACC   = 4'd4;
    localparam step_t S_DEN1  = 4'd5;
    localparam step_t S_NUM1  = 4'd6;
    localparam step_t S_DIV1  = 4'd7;
    localparam step_t S_FIN1  = 4'd8;
    localparam step_t S_SQR   = 4'd9;
    localparam step_t S_DEN2  = 4'd10;
    localparam step_t S_NUM2  = 4'd11;
    localparam step_t S_DIV2  = 4'd12;
    localparam step_t S_FIN2  = 4'd13;
    localparam step_t S_EMIT  = 4'd14;
    localparam step_t S_RET   = 4'd15;

    // Microprogram ROM.
    function automatic uword_t micro_word(step_t s);
        uword_t w;
        case (s)
            S_IDLE:  w = '{op: OP_IDLE, cond: C_WAIT,  target: S_IDLE};
            S_INIT:  w = '{op: OP_INIT, cond: C_NEXT,  target: S_IDLE};
            S_CHECK: w = '{op: OP_NOP,  cond: C_BAD,   target: S_EMIT};
            S_DIFF:  w = '{op: OP_DIFF, cond: C_NEXT,  target: S_IDLE};
            S_ACC:   w = '{op: OP_ACC,  cond: C_ORDER, target: S_DIFF};
            S_DEN1:  w = '{op: OP_DEN1, cond: C_NEXT,  target: S_IDLE};
            S_NUM1:  w = '{op: OP_NUM1, cond: C_NEXT,  target: S_IDLE};
            S_DIV1:  w = '{op: OP_DIV,  cond: C_DIV,   target: S_DIV1};
            S_FIN1:  w = '{op: OP_FIN1, cond: C_NEXT,  target: S_IDLE};
            S_SQR:   w = '{op: OP_SQR,  cond: C_NEXT,  target: S_IDLE};
            S_DEN2:  w = '{op: OP_DEN2, cond: C_NEXT,  target: S_IDLE};
            S_NUM2:  w = '{op: OP_NUM2, cond: C_NEXT,  target: S_IDLE};
            S_DIV2:  w = '{op: OP_DIV,  cond: C_DIV,   target: S_DIV2};
            S_FIN2:  w = '{op: OP_FIN2, cond: C_NEXT,  target: S_IDLE};
            S_EMIT:  w = '{op: OP_EMIT, cond: C_BUSY,  target: S_EMIT};
            S_RET:   w = '{op: OP_NOP,  cond: C_GOTO,  target: S_IDLE};
            default: w = '{op: OP_NOP,  cond: C_GOTO,  target: S_IDLE};
        endcase
        return w;
    endfunction

    // Weights of D1..D6 in 60 * f' * h.
    function automatic logic signed [COEF_W-1:0] coef_first(logic [ORD_W-1:0] k);
        logic signed [COEF_W-1:0] c;
        case (k)
            3'd1:    c = 9'sd60;
            3'd2:    c = -9'sd30;
            3'd3:    c = 9'sd20;
            3'd4:    c = -9'sd15;
            3'd5:    c = 9'sd12;
            3'd6:    c = -9'sd10;
            default: c = 9'sd0;
        endcase
        return c;
    endfunction

    // Weights of D1..D6 in 180 * f'' * h^2.
    function automatic logic signed [COEF_W-1:0] coef_second(logic [ORD_W-1:0] k);
        logic signed [COEF_W-1:0] c;
        case (k)
            3'd2:    c = 9'sd180;
            3'd3:    c = -9'sd180;
            3'd4:    c = 9'sd165;
            3'd5:    c = -9'sd150;
            3'd6:    c = 9'sd137;
            default: c = 9'sd0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/fdd_stream_if.sv =====
interface fdd_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/forward_difference_derivative_core.sv =====
// Samples that do not end a set are taken one per cycle while the program idles; a sample
// that ends a set starts the microprogram, and its result comes from two passes of the
// shared bit-serial divider, each giving a 79-bit quotient (both skipped when fewer than
// two samples or a zero step). Input stays stalled until the program returns to idle,
// later while an earlier result still waits for its beat.
// Reset (rst_n, asynchronous, active low) empties the set and drops any pending result.
module forward_difference_derivative_core
    import fdd_pkg::*;
#(
    parameter int MAX_POINTS = FDD_MAX_POINTS
) (
    input  logic clk,
    input  logic rst_n,
    fdd_stream_if.sink   samples,
    fdd_stream_if.source results
);

    op_t    op;
    flags_t flags;

    // Program ROM and step counter.
    fdd_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op)
    );

    // Sample store, difference engine, accumulators and divider.
    fdd_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results),
        .op      (op),
        .flags   (flags)
    );

endmodule

// ===== rtl/fdd_sequencer.sv =====
module fdd_sequencer
    import fdd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output op_t    op
);

    step_t  step_reg;
    step_t  step_next;
    uword_t word;
    logic   take;

    // Fetch the control word of the current step.
    assign word = micro_word(step_reg);
    assign op   = word.op;

    // Evaluate the jump condition and pick the next step.
    always_comb
    begin
        case (word.cond)
            C_NEXT:  take = 1'b0;
            C_GOTO:  take = 1'b1;
            C_WAIT:  take = !flags.pending;
            C_BAD:   take = flags.bad;
            C_ORDER: take = flags.order_more;
            C_DIV:   take = flags.div_more;
            C_BUSY:  take = flags.out_busy;
            default: take = 1'b1;
        endcase
        step_next = take ? word.target : step_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/fdd_datapath.sv =====
module fdd_datapath
    import fdd_pkg::*;
#(
    parameter int MAX_POINTS = FDD_MAX_POINTS
) (
    input  logic   clk,
    input  logic   rst_n,
    fdd_stream_if.sink   samples,
    fdd_stream_if.source results,
    input  op_t    op,
    output flags_t flags
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    // Loader state.
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W-1:0]        n_reg;
    logic signed [X_W-1:0]   first_x_reg;
    logic signed [X_W-1:0]   second_x_reg;
    logic                    pending_reg;
    logic signed [DIFF_W-1:0] v_reg [MAX_POINTS];

    // Arithmetic state.
    logic [ORD_W-1:0]        k_reg;
    logic signed [ACC_W-1:0] acc1_reg;
    logic signed [ACC_W-1:0] acc2_reg;
    logic [HMAG_W-1:0]       hmag_reg;
    logic                    hneg_reg;
    logic                    neg_reg;
    status_t                 status_reg;
    logic                    sat_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [QCNT_W-1:0]       divcnt_reg;
    logic signed [OUT_W-1:0] f1_reg;
    logic signed [OUT_W-1:0] f2_reg;
    logic                    out_valid_reg;
    result_t                 result_reg;

    sample_t                 beat;
    logic                    accept;
    logic                    count_full;
    logic signed [X_W:0]     h_full;
    logic [X_W:0]            h_mag;
    logic signed [DIFF_W-1:0] d_k;
    logic signed [DIFF_W+COEF_W-1:0] prod1;
    logic signed [DIFF_W+COEF_W-1:0] prod2;
    logic [ACC_W-1:0]        acc1_mag;
    logic [ACC_W-1:0]        acc2_mag;
    logic [2*HMAG_W-1:0]     hsq;
    logic [DEN_W:0]          rem_shift;
    logic                    rem_ge;
    logic [DEN_W:0]          rem_sub;
    logic                    q_pos_sat;
    logic                    q_neg_sat;
    logic                    fin_sat;
    logic signed [OUT_W-1:0] fin_val;
    logic                    out_busy;

    // Input handshake: samples are taken only while the program idles.
    assign beat          = samples.data;
    assign samples.ready = (op == OP_IDLE) && !pending_reg;
    assign accept        = samples.valid && samples.ready;
    assign count_full    = (count_reg == CNT_W'(MAX_POINTS));

    always_comb
    begin
        if (beat.last_sample)
        begin
            count_next = '0;
        end
        else if (count_full)
        begin
            count_next = count_reg;
        end
        else
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Step between the first two abscissas and its magnitude.
    assign h_full = {second_x_reg[X_W-1], second_x_reg} - {first_x_reg[X_W-1], first_x_reg};
    assign h_mag  = h_full[X_W] ? -h_full : h_full;

    // Current forward difference; orders the set cannot reach count as zero.
    assign d_k   = (int'(k_reg) < int'(n_reg)) ? v_reg[0] : '0;
    assign prod1 = d_k * coef_first(k_reg);
    assign prod2 = d_k * coef_second(k_reg);

    assign acc1_mag = acc1_reg[ACC_W-1] ? ACC_W'(-acc1_reg) : ACC_W'(acc1_reg);
    assign acc2_mag = acc2_reg[ACC_W-1] ? ACC_W'(-acc2_reg) : ACC_W'(acc2_reg);
    assign hsq      = hmag_reg * hmag_reg;

    // One restoring division step: shift in a numerator bit, subtract if it fits.
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    // Apply the sign to the quotient and clamp to the output range.
    assign q_pos_sat = |num_reg[NUM_W-1:OUT_W-1];
    assign q_neg_sat = (|num_reg[NUM_W-1:OUT_W]) ||
                       (num_reg[OUT_W-1] && (|num_reg[OUT_W-2:0]));
    always_comb
    begin
        if (neg_reg)
        begin
            fin_sat = q_neg_sat;
            fin_val = q_neg_sat ? NEG_LIM : OUT_W'(-num_reg[OUT_W-1:0]);
        end
        else
        begin
            fin_sat = q_pos_sat;
            fin_val = q_pos_sat ? POS_LIM : num_reg[OUT_W-1:0];
        end
    end

    // Output register: a result waits here while new samples load.
    assign out_busy      = out_valid_reg && !results.ready;
    assign results.valid = out_valid_reg;
    assign results.data  = result_reg;

    assign flags.pending    = pending_reg;
    assign flags.bad        = (status_reg != ST_OK);
    assign flags.order_more = (k_reg != ORD_W'(ORDERS));
    assign flags.div_more   = (divcnt_reg != QCNT_W'(1));
    assign flags.out_busy   = out_busy;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            first_x_reg   <= '0;
            second_x_reg  <= '0;
            pending_reg   <= 1'b0;
            k_reg         <= '0;
            status_reg    <= ST_OK;
            sat_reg       <= 1'b0;
            divcnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
                if (count_reg == CNT_W'(0))
                begin
                    first_x_reg <= beat.x_position;
                end
                if (count_reg == CNT_W'(1))
                begin
                    second_x_reg <= beat.x_position;
                end
                if (beat.last_sample)
                begin
                    pending_reg <= 1'b1;
                end
            end

            case (op)
                OP_INIT:
                begin
                    pending_reg <= 1'b0;
                    k_reg       <= '0;
                    sat_reg     <= 1'b0;
                    if (int'(n_reg) < 2)
                    begin
                        status_reg <= ST_FEW;
                    end
                    else if (h_full == '0)
                    begin
                        status_reg <= ST_ZERO;
                    end
                    else
                    begin
                        status_reg <= ST_OK;
                    end
                end
                OP_DIFF:
                begin
                    k_reg <= k_reg + ORD_W'(1);
                end
                OP_NUM1, OP_NUM2:
                begin
                    divcnt_reg <= QCNT_W'(NUM_W);
                end
                OP_DIV:
                begin
                    divcnt_reg <= divcnt_reg - QCNT_W'(1);
                end
                OP_FIN1, OP_FIN2:
                begin
                    sat_reg <= sat_reg | fin_sat;
                end
                default:
                begin
                end
            endcase

            if (op == OP_EMIT && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Sample store; the difference step rewrites it in place.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!count_full)
            begin
                v_reg[count_reg[IDX_W-1:0]] <= DIFF_W'(beat.y_value);
            end
        end
        else if (op == OP_DIFF)
        begin
            for (int i = 0; i < MAX_POINTS - 1; i++)
            begin
                v_reg[i] <= v_reg[i+1] - v_reg[i];
            end
        end
    end

    // Arithmetic payload registers.
    always_ff @(posedge clk)
    begin
        if (accept && beat.last_sample)
        begin
            n_reg <= count_full ? count_reg : count_reg + CNT_W'(1);
        end

        case (op)
            OP_INIT:
            begin
                acc1_reg <= '0;
                acc2_reg <= '0;
                f1_reg   <= '0;
                f2_reg   <= '0;
                hmag_reg <= h_mag[HMAG_W-1:0];
                hneg_reg <= h_full[X_W];
            end
            OP_ACC:
            begin
                acc1_reg <= acc1_reg + ACC_W'(prod1);
                acc2_reg <= acc2_reg + ACC_W'(prod2);
            end
            OP_DEN1:
            begin
                den_reg <= (DEN_W'(hmag_reg) << 6) - (DEN_W'(hmag_reg) << 2);
                neg_reg <= acc1_reg[ACC_W-1] ^ hneg_reg;
            end
            OP_NUM1:
            begin
                num_reg <= (NUM_W'(acc1_mag) << 16) + NUM_W'(den_reg >> 1);
                rem_reg <= '0;
            end
            OP_DIV:
            begin
                rem_reg <= rem_ge ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], rem_ge};
            end
            OP_FIN1:
            begin
                f1_reg <= fin_val;
            end
            OP_SQR:
            begin
                den_reg <= DEN_W'(hsq);
            end
            OP_DEN2:
            begin
                den_reg <= (den_reg << 7) + (den_reg << 5) + (den_reg << 4) + (den_reg << 2);
                neg_reg <= acc2_reg[ACC_W-1];
            end
            OP_NUM2:
            begin
                num_reg <= (NUM_W'(acc2_mag) << 32) + NUM_W'(den_reg >> 1);
                rem_reg <= '0;
            end
            OP_FIN2:
            begin
                f2_reg <= fin_val;
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    result_reg.first_derivative  <= f1_reg;
                    result_reg.second_derivative <= f2_reg;
                    result_reg.status            <= sat_reg ? ST_SAT : status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
